// ----- hdl/spq_pkg.sv -----
// Package for the sorted priority queue: entry type, cell control struct,
// action and status codes. Depends on nothing else.
package spq_pkg;

    // Field widths fixed by the item format.
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned HELD_W   = 5;

    // Action codes of an input item.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Status codes of a result item.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

    // One stored value/priority pair.
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] prio;
    } t_entry;

    // Control handed to each cell in every cycle.
    typedef struct packed {
        logic push;      // an insert takes effect this cycle
        logic pop;       // a removal takes effect this cycle
        logic occupied;  // this cell holds a live entry
        logic left_gt;   // the neighbor toward the head outranks the new item
    } t_cell_ctl;

endpackage

// ----- hdl/spq_if.sv -----
// Handshake interfaces for the input and result channels of the queue.
// Depends on spq_pkg for field widths.
interface spq_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic signed [spq_pkg::WORD_W-1:0]   item_value;
    logic signed [spq_pkg::WORD_W-1:0]   item_priority;

    modport source (output valid, action, item_value, item_priority, input ready);
    modport sink   (input valid, action, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
    logic                                valid;
    logic                                ready;
    logic [spq_pkg::STATUS_W-1:0]        status;
    logic signed [spq_pkg::WORD_W-1:0]   popped_value;
    logic signed [spq_pkg::WORD_W-1:0]   popped_priority;
    logic [spq_pkg::HELD_W-1:0]          entries_held;

    modport source (output valid, status, popped_value, popped_priority, entries_held,
                    input ready);
    modport sink   (input valid, status, popped_value, popped_priority, entries_held,
                    output ready);
endinterface

// ----- hdl/spq_cell.sv -----
// One compare-and-shift cell of the queue; holds a single entry.
// Depends on spq_pkg for the entry and control types.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  spq_pkg::t_entry    i_new,
    input  spq_pkg::t_entry    i_left,
    input  spq_pkg::t_entry    i_right,
    output spq_pkg::t_entry    o_entry,
    output logic               o_gt
);

    spq_pkg::t_entry r_entry;

    // A live entry with a strictly larger priority stays in front of the new item.
    assign o_gt    = i_ctl.occupied && (r_entry.prio > i_new.prio);
    assign o_entry = r_entry;

    // On a push the first cell not outranking the new item takes it and the
    // cells behind it take their left neighbor; on a pop all shift toward the head.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            if (!o_gt) begin
                r_entry <= i_ctl.left_gt ? i_new : i_left;
            end
        end else if (i_ctl.pop) begin
            r_entry <= i_right;
        end
    end

endmodule

// ----- hdl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: a row of spq_cell instances,
// the fill count and the result register. Depends on spq_pkg and spq_if.
//
//  Channel   Direction  Content
//  i_in      sink       action, item_value, item_priority
//  o_out     source     status, popped_value, popped_priority, entries_held
//
// All cells compare against the new priority in parallel and shift by one
// place at the same edge. The result is registered and appears in the cycle
// after the transfer. A new item is taken whenever the result register is
// empty or being drained, so a stalled result holds back input. The reset
// clears the fill count and the result valid and holds off input; cell
// contents need no reset.
module sorted_priority_queue #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_in_if.sink     i_in,
    spq_out_if.source  o_out
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_out_valid;
    logic [spq_pkg::STATUS_W-1:0]      r_status;
    logic [spq_pkg::STATUS_W-1:0]      n_status;
    logic signed [spq_pkg::WORD_W-1:0] r_pop_value;
    logic signed [spq_pkg::WORD_W-1:0] r_pop_prio;
    logic [CW-1:0]   r_held;

    logic            in_xfer;
    logic            do_push;
    logic            do_pop;
    spq_pkg::t_entry new_entry;
    spq_pkg::t_entry cell_q [CAPACITY];
    logic            cell_gt [CAPACITY];

    // Input is taken out of reset while the result register is free or being drained.
    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign in_xfer    = i_in.valid && i_in.ready;

    assign new_entry.value = i_in.item_value;
    assign new_entry.prio  = i_in.item_priority;

    // Decide the effect of the transfer and the next fill count.
    always_comb begin
        do_push  = 1'b0;
        do_pop   = 1'b0;
        n_count  = r_count;
        n_status = spq_pkg::ST_DONE;
        if (i_in.action == spq_pkg::ACT_PUSH) begin
            if (r_count == CW'(CAPACITY)) begin
                n_status = spq_pkg::ST_PUSH_FULL;
            end else begin
                do_push = in_xfer;
                n_count = r_count + CW'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_status = spq_pkg::ST_POP_EMPTY;
            end else begin
                do_pop  = in_xfer;
                n_count = r_count - CW'(1);
            end
        end
    end

    // Row of cells; cell 0 holds the head entry, so the row runs in
    // descending priority order.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        spq_pkg::t_cell_ctl ctl;
        spq_pkg::t_entry    left_q;
        spq_pkg::t_entry    right_q;

        if (gi == 0) begin : g_head
            assign ctl.left_gt = 1'b1;
            assign left_q      = new_entry;
        end else begin : g_body
            assign ctl.left_gt = cell_gt[gi-1];
            assign left_q      = cell_q[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign right_q = new_entry;
        end else begin : g_inner
            assign right_q = cell_q[gi+1];
        end

        assign ctl.push     = do_push;
        assign ctl.pop      = do_pop;
        assign ctl.occupied = r_count > CW'(gi);

        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_new   (new_entry),
            .i_left  (left_q),
            .i_right (right_q),
            .o_entry (cell_q[gi]),
            .o_gt    (cell_gt[gi])
        );
    end

    // Fill count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_status    <= n_status;
            r_held      <= n_count;
            r_pop_value <= do_pop ? cell_q[0].value : '0;
            r_pop_prio  <= do_pop ? cell_q[0].prio  : '0;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.popped_value    = r_pop_value;
    assign o_out.popped_priority = r_pop_prio;
    assign o_out.entries_held    = spq_pkg::HELD_W'(r_held);

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // A push into a store with room grows it by one.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.action == spq_pkg::ACT_PUSH && r_count != CW'(CAPACITY))
        |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not grow the store");

    // A rejected pop reports an empty store and no data.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == spq_pkg::ST_POP_EMPTY)
        |-> (r_held == '0 && r_pop_value == '0 && r_pop_prio == '0))
        else $error("empty pop result inconsistent");

    // The two cells nearest the head stay in descending priority order.
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (cell_q[0].prio >= cell_q[1].prio))
        else $error("cell row out of order");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench for sorted_priority_queue: a table of directed push/pop rows, then
// random traffic, checked against each typed row's own expectation or a sorted-store predictor.
// Depends on spq_pkg, spq_if and the block itself.
module tb;
    import spq_pkg::*;

    localparam int unsigned DEPTH = 16;
    localparam int RANDOM_ITEMS = 925;
    localparam int CALM_ITEMS   = 150;
    localparam int DRAIN_AT     = 400;
    localparam int MAX_REPORTS  = 10;

    // One result of the queue, as seen on the output channel.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] prio;
        logic [HELD_W-1:0]        held;
    } t_result;

    // One row of the directed table; typed rows carry their own expectation.
    typedef struct packed {
        logic                     action;
        logic signed [WORD_W-1:0] value;
        logic signed [WORD_W-1:0] prio;
        logic                     typed;
        t_result                  want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue #(.CAPACITY(DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted contents of the store, ascending by priority.
    t_entry      sorted_store [DEPTH];
    int unsigned store_fill;
    t_result     pending_results [$];
    int          mismatch_count;
    int          stall_left;
    logic        calm;
    logic        row_typed;
    t_result     row_want;

    // Pop on empty, single-entry pop, filling to capacity with ties and
    // extremes, push on full, then pops that must come out highest priority first, newest first on ties.
    t_row directed_rows [25] = '{
        '{ACT_POP,  32'sh1234_5678, 32'sh0000_0001, 1'b1, '{ST_POP_EMPTY, 32'sd0, 32'sd0, 5'd0}},
        '{ACT_PUSH, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd1}},
        '{ACT_POP,  32'sh0000_0000, 32'sh0000_0000, 1'b1,
          '{ST_DONE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 5'd0}},
        '{ACT_POP,  32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1, '{ST_POP_EMPTY, 32'sd0, 32'sd0, 5'd0}},
        '{ACT_PUSH, 32'sh8000_0000, 32'sd5,         1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd1}},
        '{ACT_PUSH, 32'shFFFF_FFFF, 32'sh8000_0000, 1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd2}},
        '{ACT_PUSH, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd3}},
        '{ACT_PUSH, 32'sd0,         32'sd5,         1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd4}},
        '{ACT_PUSH, 32'sd1,         32'sd5,         1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd5}},
        '{ACT_PUSH, 32'sd2,         -32'sd1,        1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd6}},
        '{ACT_PUSH, 32'sd3,         32'sd0,         1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd7}},
        '{ACT_PUSH, 32'sd4,         32'sh7FFF_FFFF, 1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd8}},
        '{ACT_PUSH, 32'sd5,         32'sh8000_0000, 1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd9}},
        '{ACT_PUSH, 32'sd6,         32'sd5,         1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd10}},
        '{ACT_PUSH, 32'sd7,         32'sd100,       1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd11}},
        '{ACT_PUSH, 32'sd8,         -32'sd100,      1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd12}},
        '{ACT_PUSH, 32'sd9,         32'sd0,         1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd13}},
        '{ACT_PUSH, 32'sd10,        32'sh5555_5555, 1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd14}},
        '{ACT_PUSH, 32'sd11,        32'shAAAA_AAAA, 1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd15}},
        '{ACT_PUSH, 32'sd12,        32'sd5,         1'b1, '{ST_DONE, 32'sd0, 32'sd0, 5'd16}},
        '{ACT_PUSH, 32'sd13,        32'sd1,         1'b1, '{ST_PUSH_FULL, 32'sd0, 32'sd0, 5'd16}},
        '{ACT_POP,  32'sd0,         32'sd0,         1'b0, '0},
        '{ACT_POP,  32'sd0,         32'sd0,         1'b0, '0},
        '{ACT_POP,  32'sd0,         32'sd0,         1'b0, '0},
        '{ACT_POP,  32'sd0,         32'sd0,         1'b0, '0}
    };

    // Clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one push or pop to the predicted store and return its result.
    function automatic t_result predict_queue_op(logic action,
                                                 logic signed [WORD_W-1:0] item_val,
                                                 logic signed [WORD_W-1:0] item_pri);
        t_result     res;
        int unsigned pos;
        res        = '0;
        res.status = ST_DONE;
        if (action == ACT_PUSH) begin
            if (store_fill >= DEPTH) begin
                res.status = ST_PUSH_FULL;
            end else begin
                // Entries with a strictly larger priority move up one slot.
                pos = store_fill;
                while (pos > 0 && sorted_store[pos-1].prio > item_pri) begin
                    sorted_store[pos] = sorted_store[pos-1];
                    pos--;
                end
                sorted_store[pos] = '{value: item_val, prio: item_pri};
                store_fill++;
            end
        end else if (store_fill == 0) begin
            res.status = ST_POP_EMPTY;
        end else begin
            store_fill--;
            res.value = sorted_store[store_fill].value;
            res.prio  = sorted_store[store_fill].prio;
        end
        res.held = store_fill[HELD_W-1:0];
        return res;
    endfunction

    // Check results first, then predict for the transfer taken at this edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result guess;
        if (i_rst_n === 1'b1) begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got = '{out_ch.status, out_ch.popped_value, out_ch.popped_priority,
                        out_ch.entries_held};
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: status %0d value %0d",
                                 $realtime, got.status, got.value);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.value !== want.value ||
                        got.prio !== want.prio || got.held !== want.held) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $write("%0t: mismatch (exp/act) status %0d/%0d value %0d/%0d ",
                                   $realtime, want.status, got.status, want.value,
                                   got.value);
                            $display("priority %0d/%0d held %0d/%0d",
                                     want.prio, got.prio, want.held, got.held);
                        end
                    end
                end
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                guess = predict_queue_op(in_ch.action, in_ch.item_value, in_ch.item_priority);
                pending_results.push_back(row_typed ? row_want : guess);
            end
        end
    end

    // Result side: ready drops in bursts of random length, never when calm.
    always @(negedge i_clk) begin
        if (calm) begin
            out_ch.ready <= 1'b1;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 14);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Offer one item, maybe after an idle burst, and wait for its transfer.
    // Called at a falling edge and returns at a falling edge.
    task automatic send_item(input logic action, input logic signed [WORD_W-1:0] item_val,
                             input logic signed [WORD_W-1:0] item_pri, input logic typed,
                             input t_result want);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= action;
        in_ch.item_value    <= item_val;
        in_ch.item_priority <= item_pri;
        row_typed           <= typed;
        row_want            <= want;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stimulus.
    initial begin
        int                       seg_left;
        int                       push_pct;
        int                       pick;
        logic                     act;
        logic signed [WORD_W-1:0] pri;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.action        = ACT_PUSH;
        in_ch.item_value    = '0;
        in_ch.item_priority = '0;
        out_ch.ready        = 1'b0;
        row_typed           = 1'b0;
        row_want            = '0;
        calm                = 1'b0;
        stall_left          = 0;
        store_fill          = 0;
        mismatch_count      = 0;
        seg_left            = 0;
        push_pct            = 50;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].action, directed_rows[r].value, directed_rows[r].prio,
                      directed_rows[r].typed, directed_rows[r].want);

        // Random part: segments lean toward pushes or pops so the store
        // swings between empty and full; priorities favor a small range
        // to make ties common.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == DRAIN_AT) begin
                in_ch.valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            if (k == RANDOM_ITEMS - CALM_ITEMS)
                calm <= 1'b1;
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
            end
            seg_left--;
            act  = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
            pick = $urandom_range(0, 19);
            if (pick < 10)
                pri = $urandom_range(0, 7) - 4;
            else if (pick < 13)
                pri = pick[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            else
                pri = $urandom();
            send_item(act, $urandom(), pri, 1'b0, '0);
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
test/tb.sv
